// ===== src/dra_pkg.sv =====
// Shared types and constants of the DNS response address extractor.
`default_nettype none
package dra_pkg;

  typedef enum logic [22:0] {
    PH_ID_HI     = 23'h000001,
    PH_ID_LO     = 23'h000002,
    PH_FLAGS1    = 23'h000004,
    PH_FLAGS2    = 23'h000008,
    PH_QD_HI     = 23'h000010,
    PH_QD_LO     = 23'h000020,
    PH_AN_HI     = 23'h000040,
    PH_AN_LO     = 23'h000080,
    PH_HDR_REST  = 23'h000100,
    PH_NAME_LEN  = 23'h000200,
    PH_NAME_LBL  = 23'h000400,
    PH_NAME_PTR  = 23'h000800,
    PH_QFIXED    = 23'h001000,
    PH_TYPE_HI   = 23'h002000,
    PH_TYPE_LO   = 23'h004000,
    PH_CLASS_HI  = 23'h008000,
    PH_CLASS_LO  = 23'h010000,
    PH_TTL       = 23'h020000,
    PH_RDLEN_HI  = 23'h040000,
    PH_RDLEN_LO  = 23'h080000,
    PH_RDATA     = 23'h100000,
    PH_DONE      = 23'h200000,
    PH_ERROR     = 23'h400000
  } phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ID       = 3'd1;
  localparam logic [2:0] ST_NOTRESP  = 3'd2;
  localparam logic [2:0] ST_NXDOMAIN = 3'd3;
  localparam logic [2:0] ST_SERVFAIL = 3'd4;
  localparam logic [2:0] ST_CLASS    = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;
  localparam logic [2:0] ST_SHORT    = 3'd7;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] CLASS_IN  = 16'd1;

  localparam logic [4:0] LEN_A    = 5'd4;
  localparam logic [4:0] LEN_AAAA = 5'd16;
  localparam logic [4:0] LEN_NONE = 5'd0;

  localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;
  localparam logic [1:0]  LABEL_PTR      = 2'b11;
  localparam logic [15:0] FIXED_LEN      = 16'd4;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic        result_kind;
    logic        addr_family;
    logic [15:0] addr_ordinal;
    logic [3:0]  byte_position;
    logic [7:0]  addr_byte;
    logic        addr_done;
    logic [2:0]  status;
    logic [15:0] address_total;
    logic        last_result;
  } result_t;

endpackage
`default_nettype wire

// ===== src/dra_ifs.sv =====
// Handshake channels of the DNS response address extractor.
`default_nettype none
interface dra_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dra_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        addr_family;
  logic [15:0] addr_ordinal;
  logic [3:0]  byte_position;
  logic [7:0]  addr_byte;
  logic        addr_done;
  logic [2:0]  status;
  logic [15:0] address_total;
  logic        last_result;
  modport source (output valid, output result_kind, output addr_family,
                  output addr_ordinal, output byte_position, output addr_byte,
                  output addr_done, output status, output address_total,
                  output last_result, input ready);
  modport sink (input valid, input result_kind, input addr_family,
                input addr_ordinal, input byte_position, input addr_byte,
                input addr_done, input status, input address_total,
                input last_result, output ready);
endinterface

interface dra_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] expected_id;
  modport source (output valid, output expected_id, input ready);
  modport sink (input valid, input expected_id, output ready);
endinterface
`default_nettype wire

// ===== src/dns_response_address_extractor.sv =====
// Top level of the DNS response address extractor.
//
// bytes: one DNS message byte per item, last_byte set on the final byte.
// results: address-byte items for A and AAAA records, then one status item
//   at the end of every message; last_result closes the items of one byte.
// cfg: writes expected_id; always ready, write only while idle.
// Each accepted byte updates the parse state in the cycle it is taken and
// pushes zero, one or two items into a four-entry result queue; the head of
// the queue is registered and drives results in the order items were pushed.
// Throughput is one byte per cycle while the queue has room: it accepts a
// byte while it holds two items or fewer, so a stalled receiver stops the
// byte channel after the queue fills; a final byte that carries an address
// byte takes a second queue slot for the status item.
// Reset returns the parse state to the first ID byte, empties the queue and clears expected_id to zero.
`default_nettype none
module dns_response_address_extractor
  import dra_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  dra_in_if.sink    bytes,
  dra_out_if.source results,
  dra_cfg_if.sink   cfg
);

  localparam int CW = $clog2(QDEPTH + 1);

  logic [15:0] expected_id;
  phase_t      phase, phase_next;
  logic [15:0] fbc, fbc_next;
  logic [7:0]  hold, hold_next;
  logic [15:0] qleft, qleft_next;
  logic [15:0] aleft, aleft_next;
  logic [7:0]  lbl, lbl_next;
  logic [15:0] rtype, rtype_next;
  logic [15:0] rdleft, rdleft_next;
  logic [2:0]  err, err_next;
  logic [15:0] emitted, emitted_next;

  result_t     q [QDEPTH];
  result_t     q_next [QDEPTH];
  logic [CW-1:0] count, count_next;

  logic        acc, pop;
  logic [7:0]  b;
  logic [15:0] hv;
  logic [4:0]  alen;
  logic        a_valid, s_valid;
  result_t     a_res, s_res, r0, r1;
  logic [CW-1:0] base;

  assign b   = bytes.data_byte;
  assign hv  = {hold, b};
  assign acc = bytes.valid && bytes.ready;
  assign pop = (count != '0) && results.ready;
  assign bytes.ready = (count <= CW'(QDEPTH - 2));
  assign cfg.ready = 1'b1;

  always_comb begin
    if (rtype == TYPE_A) begin
      alen = LEN_A;
    end else if (rtype == TYPE_AAAA) begin
      alen = LEN_AAAA;
    end else begin
      alen = LEN_NONE;
    end
  end

  always_comb begin
    logic [15:0] qdec;
    logic [15:0] adec;
    logic [15:0] rdv;
    logic [15:0] rdm;
    qdec = qleft - 16'd1;
    adec = (aleft != 16'd0) ? aleft - 16'd1 : aleft;
    rdv  = hv;
    rdm  = rdleft - 16'd1;
    phase_next   = phase;
    fbc_next     = fbc;
    hold_next    = hold;
    qleft_next   = qleft;
    aleft_next   = aleft;
    lbl_next     = lbl;
    rtype_next   = rtype;
    rdleft_next  = rdleft;
    err_next     = err;
    emitted_next = emitted;
    a_valid = 1'b0;
    a_res   = '0;
    s_valid = 1'b0;
    s_res   = '0;
    case (phase)
      PH_ID_HI: begin
        hold_next  = b;
        phase_next = PH_ID_LO;
      end
      PH_ID_LO: begin
        if (hv != expected_id) begin
          err_next   = ST_ID;
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_FLAGS1;
        end
      end
      PH_FLAGS1: begin
        if (!b[7]) begin
          err_next   = ST_NOTRESP;
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_FLAGS2;
        end
      end
      PH_FLAGS2: begin
        if (b[3:0] == RCODE_NXDOMAIN) begin
          err_next   = ST_NXDOMAIN;
          phase_next = PH_ERROR;
        end else if (b[3:0] != 4'd0) begin
          err_next   = ST_SERVFAIL;
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_QD_HI;
        end
      end
      PH_QD_HI: begin
        hold_next  = b;
        phase_next = PH_QD_LO;
      end
      PH_QD_LO: begin
        qleft_next = hv;
        phase_next = PH_AN_HI;
      end
      PH_AN_HI: begin
        hold_next  = b;
        phase_next = PH_AN_LO;
      end
      PH_AN_LO: begin
        aleft_next = hv;
        fbc_next   = '0;
        phase_next = PH_HDR_REST;
      end
      PH_HDR_REST: begin
        fbc_next = fbc + 16'd1;
        if (fbc_next >= FIXED_LEN) begin
          phase_next = (qleft != 16'd0 || aleft != 16'd0) ? PH_NAME_LEN : PH_DONE;
        end
      end
      PH_NAME_LEN: begin
        if (b[7:6] == LABEL_PTR) begin
          phase_next = PH_NAME_PTR;
        end else if (b == 8'd0) begin
          fbc_next   = '0;
          phase_next = (qleft != 16'd0) ? PH_QFIXED : PH_TYPE_HI;
        end else begin
          lbl_next   = b;
          phase_next = PH_NAME_LBL;
        end
      end
      PH_NAME_LBL: begin
        lbl_next = lbl - 8'd1;
        if (lbl_next == 8'd0) begin
          phase_next = PH_NAME_LEN;
        end
      end
      PH_NAME_PTR: begin
        fbc_next   = '0;
        phase_next = (qleft != 16'd0) ? PH_QFIXED : PH_TYPE_HI;
      end
      PH_QFIXED: begin
        fbc_next = fbc + 16'd1;
        if (fbc_next >= FIXED_LEN) begin
          qleft_next = qdec;
          phase_next = (qdec != 16'd0 || aleft != 16'd0) ? PH_NAME_LEN : PH_DONE;
        end
      end
      PH_TYPE_HI: begin
        hold_next  = b;
        phase_next = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        rtype_next = hv;
        phase_next = PH_CLASS_HI;
      end
      PH_CLASS_HI: begin
        hold_next  = b;
        phase_next = PH_CLASS_LO;
      end
      PH_CLASS_LO: begin
        if (hv != CLASS_IN) begin
          err_next   = ST_CLASS;
          phase_next = PH_ERROR;
        end else begin
          fbc_next   = '0;
          phase_next = PH_TTL;
        end
      end
      PH_TTL: begin
        fbc_next = fbc + 16'd1;
        if (fbc_next >= FIXED_LEN) begin
          phase_next = PH_RDLEN_HI;
        end
      end
      PH_RDLEN_HI: begin
        hold_next  = b;
        phase_next = PH_RDLEN_LO;
      end
      PH_RDLEN_LO: begin
        rdleft_next = rdv;
        if (rdv < {11'd0, alen}) begin
          err_next   = ST_SHORT;
          phase_next = PH_ERROR;
        end else if (rdv == 16'd0) begin
          aleft_next = adec;
          phase_next = (qleft != 16'd0 || adec != 16'd0) ? PH_NAME_LEN : PH_DONE;
        end else begin
          fbc_next   = '0;
          phase_next = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (fbc < {11'd0, alen}) begin
          a_valid              = 1'b1;
          a_res.addr_family    = (rtype == TYPE_AAAA);
          a_res.addr_ordinal   = emitted;
          a_res.byte_position  = fbc[3:0];
          a_res.addr_byte      = b;
          a_res.addr_done      = (fbc == {11'd0, alen} - 16'd1);
          if (a_res.addr_done && emitted != COUNT_MAX) begin
            emitted_next = emitted + 16'd1;
          end
        end
        fbc_next    = fbc + 16'd1;
        rdleft_next = rdm;
        if (rdm == 16'd0) begin
          aleft_next = adec;
          phase_next = (qleft != 16'd0 || adec != 16'd0) ? PH_NAME_LEN : PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (bytes.last_byte) begin
      s_valid             = 1'b1;
      s_res.result_kind   = 1'b1;
      s_res.status        = (err_next == ST_OK && phase_next != PH_DONE) ? ST_TRUNC : err_next;
      s_res.address_total = emitted_next;
      s_res.last_result   = 1'b1;
      phase_next   = PH_ID_HI;
      fbc_next     = '0;
      hold_next    = '0;
      qleft_next   = '0;
      aleft_next   = '0;
      lbl_next     = '0;
      rtype_next   = '0;
      rdleft_next  = '0;
      err_next     = ST_OK;
      emitted_next = '0;
    end
    a_res.last_result = !s_valid;
  end

  always_comb begin
    r0   = a_valid ? a_res : s_res;
    r1   = s_res;
    base = count - CW'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (acc && (a_valid || s_valid) && base == CW'(i)) begin
        q_next[i] = r0;
      end
      if (acc && a_valid && s_valid && base + CW'(1) == CW'(i)) begin
        q_next[i] = r1;
      end
    end
    count_next = base + CW'(acc && (a_valid || s_valid)) + CW'(acc && a_valid && s_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
      phase       <= PH_ID_HI;
      fbc         <= '0;
      hold        <= '0;
      qleft       <= '0;
      aleft       <= '0;
      lbl         <= '0;
      rtype       <= '0;
      rdleft      <= '0;
      err         <= ST_OK;
      emitted     <= '0;
      count       <= '0;
    end else begin
      if (cfg.valid) begin
        expected_id <= cfg.expected_id;
      end
      if (acc) begin
        phase   <= phase_next;
        fbc     <= fbc_next;
        hold    <= hold_next;
        qleft   <= qleft_next;
        aleft   <= aleft_next;
        lbl     <= lbl_next;
        rtype   <= rtype_next;
        rdleft  <= rdleft_next;
        err     <= err_next;
        emitted <= emitted_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign results.valid         = (count != '0);
  assign results.result_kind   = q[0].result_kind;
  assign results.addr_family   = q[0].addr_family;
  assign results.addr_ordinal  = q[0].addr_ordinal;
  assign results.byte_position = q[0].byte_position;
  assign results.addr_byte     = q[0].addr_byte;
  assign results.addr_done     = q[0].addr_done;
  assign results.status        = q[0].status;
  assign results.address_total = q[0].address_total;
  assign results.last_result   = q[0].last_result;

endmodule
`default_nettype wire
